[design/vnf_pkg.sv]
`default_nettype none
package vnf_pkg;

  localparam int unsigned OCTAVES_DEF = 4;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned FREQ_W  = 24;
  localparam int unsigned GAIN_W  = 12;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned HGT_W   = 20;
  localparam int unsigned PROD_W  = COORD_W + FREQ_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_GAIN = 2'd1;

  localparam logic [FREQ_W-1:0] FREQ_RST = 24'd587203;
  localparam logic [GAIN_W-1:0] GAIN_RST = 12'd2048;

  localparam logic [31:0] HMUL_X   = 32'd374761393;
  localparam logic [31:0] HMUL_Z   = 32'd668265263;
  localparam logic [31:0] HMUL_MIX = 32'd1274126177;
  localparam int unsigned HSHIFT   = 13;

  localparam int unsigned OCT_LAT = 5;

endpackage
`default_nettype wire

[design/vnf_octave.sv]
`default_nettype none
module vnf_octave #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [vnf_pkg::PROD_W-1:0] px_i,
  input  wire logic signed [vnf_pkg::PROD_W-1:0] pz_i,
  output logic [vnf_pkg::FRAC_W-1:0]             noise_o
);

  localparam int unsigned EW = vnf_pkg::PROD_W + 16;

  logic [EW-1:0] ex, ez;
  logic [31:0]   ix, iz;
  logic [15:0]   fx, fz;

  assign ex = {{16{px_i[vnf_pkg::PROD_W-1]}}, px_i} << SHIFT;
  assign ez = {{16{pz_i[vnf_pkg::PROD_W-1]}}, pz_i} << SHIFT;
  assign ix = ex[71:40];
  assign iz = ez[71:40];
  assign fx = ex[39:24];
  assign fz = ez[39:24];

  // stage A
  logic [31:0] hx_q, hz_q, ffx_q, ffz_q;
  logic [17:0] kx_q, kz_q;
  // stage B
  logic [31:0] h_q [4];
  logic [15:0] wu_q, wv_q;
  // stage C
  logic [15:0] c_q [4];
  logic [15:0] wu2_q, wv2_q;
  // stage D
  logic [15:0] l0_q, l1_q, wv3_q;
  // stage E
  logic [15:0] n_q;

  logic [31:0] hsum [4];
  logic [31:0] hmix [4];
  logic [49:0] wx_p, wz_p;
  logic [32:0] b0, b1, b2;
  logic [16:0] iu, iv;

  always_comb begin
    hsum[0] = hx_q + hz_q;
    hsum[1] = hx_q + vnf_pkg::HMUL_X + hz_q;
    hsum[2] = hx_q + hz_q + vnf_pkg::HMUL_Z;
    hsum[3] = hx_q + vnf_pkg::HMUL_X + hz_q + vnf_pkg::HMUL_Z;
    for (int k = 0; k < 4; k++) begin
      hmix[k] = (h_q[k] ^ 32'($signed(h_q[k]) >>> vnf_pkg::HSHIFT)) * vnf_pkg::HMUL_MIX;
    end
    wx_p = 50'(ffx_q) * 50'(kx_q);
    wz_p = 50'(ffz_q) * 50'(kz_q);
    iu = 17'd65536 - 17'(wu2_q);
    iv = 17'd65536 - 17'(wv3_q);
    b0 = 33'(c_q[0]) * 33'(iu) + 33'(c_q[1]) * 33'(wu2_q);
    b1 = 33'(c_q[2]) * 33'(iu) + 33'(c_q[3]) * 33'(wu2_q);
    b2 = 33'(l0_q) * 33'(iv) + 33'(l1_q) * 33'(wv3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hx_q  <= ix * vnf_pkg::HMUL_X;
      hz_q  <= iz * vnf_pkg::HMUL_Z;
      ffx_q <= 32'(fx) * 32'(fx);
      ffz_q <= 32'(fz) * 32'(fz);
      kx_q  <= 18'd196608 - {1'b0, fx, 1'b0};
      kz_q  <= 18'd196608 - {1'b0, fz, 1'b0};
      for (int k = 0; k < 4; k++) begin
        h_q[k] <= hsum[k];
        c_q[k] <= hmix[k][30:15];
      end
      wu_q  <= wx_p[47:32];
      wv_q  <= wz_p[47:32];
      wu2_q <= wu_q;
      wv2_q <= wv_q;
      l0_q  <= b0[31:16];
      l1_q  <= b1[31:16];
      wv3_q <= wv2_q;
      n_q   <= b2[31:16];
    end
  end

  assign noise_o = n_q;

endmodule
`default_nettype wire

[design/value_noise_fbm_height.sv]
`default_nettype none
// Fractal value-noise terrain height.
// Input stream s_axis: one transaction carries a signed Q16.16 world coordinate
// pair; output stream m_axis returns one unsigned Q4.16 height per input, in order.
// Config port: cfg_we_i writes register cfg_idx_i (0 base frequency Q0.24,
// 1 height gain Q4.8) with cfg_wdata_i; other indexes are ignored. Write only
// while the pipeline is empty.
// Pipeline: coordinate, frequency product, octave stages A to E, sum, height.
// Throughput: one transaction per clock while not stalled; every octave has its
// own lane of multipliers, so all octaves of a sample run side by side.
// Stall: when the output register is full and m_axis_tready is low the whole
// pipeline holds and s_axis_tready drops; nothing is lost or repeated.
// Reset: all valid bits clear, registers return to 0.035 and 8.0.
module value_noise_fbm_height #(
  parameter int unsigned OCTAVES = vnf_pkg::OCTAVES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [63:0]                     s_axis_tdata,  // coord_x, coord_z
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [23:0]                          m_axis_tdata,  // height, zero pad
  input  wire logic                            cfg_we_i,
  input  wire logic [vnf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [vnf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned NSTG  = vnf_pkg::OCT_LAT + 4;
  localparam int unsigned SUM_W = vnf_pkg::FRAC_W + OCTAVES;
  localparam int unsigned MUL_W = SUM_W + vnf_pkg::GAIN_W;

  logic [vnf_pkg::FREQ_W-1:0] freq_q;
  logic [vnf_pkg::GAIN_W-1:0] gain_q;
  logic [NSTG-1:0]            vld_q;
  logic                       en;

  assign en = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= vnf_pkg::FREQ_RST;
      gain_q <= vnf_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == vnf_pkg::REG_BASE_FREQ) begin
        freq_q <= cfg_wdata_i[vnf_pkg::FREQ_W-1:0];
      end else if (cfg_idx_i == vnf_pkg::REG_HEIGHT_GAIN) begin
        gain_q <= cfg_wdata_i[vnf_pkg::GAIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  logic signed [31:0]                  x_q, z_q;
  logic signed [vnf_pkg::PROD_W-1:0]   px_q, pz_q;
  logic signed [vnf_pkg::PROD_W:0]     px, pz;

  assign px = x_q * $signed({1'b0, freq_q});
  assign pz = z_q * $signed({1'b0, freq_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q  <= s_axis_tdata[31:0];
      z_q  <= s_axis_tdata[63:32];
      px_q <= px[vnf_pkg::PROD_W-1:0];
      pz_q <= pz[vnf_pkg::PROD_W-1:0];
    end
  end

  logic [vnf_pkg::FRAC_W-1:0] noise [OCTAVES];

  for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
    vnf_octave #(.SHIFT(g)) u_oct (
      .clk_i   (clk_i),
      .en_i    (en),
      .px_i    (px_q),
      .pz_i    (pz_q),
      .noise_o (noise[g])
    );
  end

  logic [SUM_W-1:0] sum, sum_q;
  logic [MUL_W-1:0] prod;
  logic [vnf_pkg::HGT_W-1:0] hgt_q;

  always_comb begin
    sum = '0;
    for (int i = 0; i < OCTAVES; i++) begin
      sum = sum + (SUM_W'(noise[i]) << (OCTAVES - 1 - i));
    end
    prod = MUL_W'(sum_q) * MUL_W'(gain_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sum;
      hgt_q <= prod[OCTAVES+8+vnf_pkg::HGT_W-1:OCTAVES+8];
    end
  end

  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = {4'd0, hgt_q};

endmodule
`default_nettype wire
